// ----- design/eabv_pkg.sv -----
// eabv_pkg: shared types, constants and fixed-point helpers for the basis vector block
// holds the quarter-wave sine rom, built at elaboration from a q30 series
// no dependencies
package eabv_pkg;

  localparam int ANGLE_BITS  = 16;
  localparam int FRAC_BITS   = 14;
  localparam int TABLE_DEPTH = 1024;
  localparam int FIELD_BITS  = 16;

  localparam int DEPTH_BITS  = $clog2(TABLE_DEPTH);
  localparam int IDX_BITS    = DEPTH_BITS + 1;
  localparam int MAG_BITS    = FRAC_BITS + 1;
  localparam int POS_BITS    = ANGLE_BITS - 2;
  localparam int SCALE_BITS  = POS_BITS + IDX_BITS;
  localparam int PROD_BITS   = 2 * FIELD_BITS;
  localparam int SUM_BITS    = FIELD_BITS + 1;

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
  localparam int              Q30_SHIFT   = 30 - FRAC_BITS;

  typedef struct packed {
    logic [FIELD_BITS-1:0] pitch_angle;
    logic [FIELD_BITS-1:0] yaw_angle;
    logic [FIELD_BITS-1:0] roll_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] forward_x;
    logic signed [FIELD_BITS-1:0] forward_y;
    logic signed [FIELD_BITS-1:0] forward_z;
    logic signed [FIELD_BITS-1:0] right_x;
    logic signed [FIELD_BITS-1:0] right_y;
    logic signed [FIELD_BITS-1:0] right_z;
    logic signed [FIELD_BITS-1:0] up_x;
    logic signed [FIELD_BITS-1:0] up_y;
    logic signed [FIELD_BITS-1:0] up_z;
  } out_item_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] sin_val;
    logic signed [FIELD_BITS-1:0] cos_val;
  } trig_pair_t;

  typedef logic [MAG_BITS-1:0] sine_rom_t [0:TABLE_DEPTH];

  function automatic longint unsigned sine_q30(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(Q30_ONE)) begin
      sum = longint'(Q30_ONE);
    end
    return longint'(sum);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t       rom;
    longint unsigned x;
    longint unsigned s;
    for (int i = 0; i <= TABLE_DEPTH; i++) begin
      x = (Q30_HALF_PI * longint'(i) + longint'(TABLE_DEPTH / 2)) >> DEPTH_BITS;
      s = sine_q30(x);
      if (Q30_SHIFT > 0) begin
        s = (s + (64'd1 << (Q30_SHIFT - 1))) >> Q30_SHIFT;
      end
      rom[i] = s[MAG_BITS-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // product rounded half up, floor of (a*b + half) / 2^frac
  function automatic logic signed [FIELD_BITS-1:0] mul_round(
    input logic signed [FIELD_BITS-1:0] a,
    input logic signed [FIELD_BITS-1:0] b
  );
    logic signed [PROD_BITS-1:0] p;
    p = PROD_BITS'(a) * PROD_BITS'(b);
    p = (p + (PROD_BITS'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return p[FIELD_BITS-1:0];
  endfunction

  function automatic logic signed [FIELD_BITS-1:0] sat_unit(
    input logic signed [SUM_BITS-1:0] v
  );
    logic signed [SUM_BITS-1:0] one;
    logic signed [SUM_BITS-1:0] r;
    one = SUM_BITS'(1) <<< FRAC_BITS;
    if (v > one) begin
      r = one;
    end else if (v < -one) begin
      r = -one;
    end else begin
      r = v;
    end
    return r[FIELD_BITS-1:0];
  endfunction

endpackage

// ----- design/eabv_lane.sv -----
// eabv_lane: sine and cosine of one binary angle from the quarter-wave rom
// dual registered rom read, sign applied on the output side
// depends on eabv_pkg
module eabv_lane (
  input  logic                                clk,
  input  logic                                en,
  input  logic [eabv_pkg::FIELD_BITS-1:0]     angle,
  output eabv_pkg::trig_pair_t                trig
);

  logic [eabv_pkg::ANGLE_BITS-1:0] ang;
  logic [1:0]                      quad;
  logic [1:0]                      cos_quad;
  logic [eabv_pkg::POS_BITS-1:0]   pos;
  logic [eabv_pkg::SCALE_BITS-1:0] scaled;
  logic [eabv_pkg::IDX_BITS-1:0]   idx_raw;
  logic [eabv_pkg::IDX_BITS-1:0]   idx;
  logic [eabv_pkg::IDX_BITS-1:0]   idx_mirror;
  logic [eabv_pkg::IDX_BITS-1:0]   sin_idx;
  logic [eabv_pkg::IDX_BITS-1:0]   cos_idx;

  logic [eabv_pkg::MAG_BITS-1:0]   sin_mag_r;
  logic [eabv_pkg::MAG_BITS-1:0]   cos_mag_r;
  logic                            sin_neg_r;
  logic                            cos_neg_r;

  logic signed [eabv_pkg::FIELD_BITS-1:0] sin_abs;
  logic signed [eabv_pkg::FIELD_BITS-1:0] cos_abs;

  always_comb begin
    ang      = angle[eabv_pkg::ANGLE_BITS-1:0];
    quad     = ang[eabv_pkg::ANGLE_BITS-1 -: 2];
    cos_quad = quad + 2'd1;
    pos      = ang[eabv_pkg::POS_BITS-1:0];
    scaled   = eabv_pkg::SCALE_BITS'(pos) * eabv_pkg::SCALE_BITS'(eabv_pkg::TABLE_DEPTH)
             + (eabv_pkg::SCALE_BITS'(1) << (eabv_pkg::POS_BITS - 1));
    idx_raw  = scaled[eabv_pkg::SCALE_BITS-1:eabv_pkg::POS_BITS];
    if (idx_raw > eabv_pkg::IDX_BITS'(eabv_pkg::TABLE_DEPTH)) begin
      idx = eabv_pkg::IDX_BITS'(eabv_pkg::TABLE_DEPTH);
    end else begin
      idx = idx_raw;
    end
    idx_mirror = eabv_pkg::IDX_BITS'(eabv_pkg::TABLE_DEPTH) - idx;
    sin_idx    = quad[0] ? idx_mirror : idx;
    cos_idx    = cos_quad[0] ? idx_mirror : idx;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_mag_r <= eabv_pkg::SINE_ROM[sin_idx];
      cos_mag_r <= eabv_pkg::SINE_ROM[cos_idx];
      sin_neg_r <= quad[1];
      cos_neg_r <= cos_quad[1];
    end
  end

  always_comb begin
    sin_abs      = eabv_pkg::FIELD_BITS'(sin_mag_r);
    cos_abs      = eabv_pkg::FIELD_BITS'(cos_mag_r);
    trig.sin_val = sin_neg_r ? -sin_abs : sin_abs;
    trig.cos_val = cos_neg_r ? -cos_abs : cos_abs;
  end

endmodule

// ----- design/eabv_merge.sv -----
// eabv_merge: combines the three lanes into forward, right and up vectors
// two registered multiply stages, then sums of the rounded products saturated to the unit range
// depends on eabv_pkg
module eabv_merge (
  input  logic                  clk,
  input  logic                  en,
  input  eabv_pkg::trig_pair_t  pitch,
  input  eabv_pkg::trig_pair_t  yaw,
  input  eabv_pkg::trig_pair_t  roll,
  output eabv_pkg::out_item_t   result
);

  localparam int W = eabv_pkg::FIELD_BITS;
  localparam int S = eabv_pkg::SUM_BITS;

  // first product stage
  logic signed [W-1:0] cpcy_r, cpsy_r, srsp_r, crsp_r, nsrcp_r, crcp_r;
  logic signed [W-1:0] crsy_r, crcy_r, srsy_r, srcy_r, nsp_r, cy_r, sy_r;

  // second product stage
  logic signed [W-1:0] srspcy_r, srspsy_r, crspcy_r, crspsy_r;
  logic signed [W-1:0] crsy2_r, crcy2_r, srsy2_r, srcy2_r;
  logic signed [W-1:0] cpcy2_r, cpsy2_r, nsp2_r, nsrcp2_r, crcp2_r;

  logic signed [S-1:0] rx_sum, ry_sum, ux_sum, uy_sum;

  always_ff @(posedge clk) begin
    if (en) begin
      cpcy_r  <= eabv_pkg::mul_round(pitch.cos_val, yaw.cos_val);
      cpsy_r  <= eabv_pkg::mul_round(pitch.cos_val, yaw.sin_val);
      srsp_r  <= eabv_pkg::mul_round(roll.sin_val, pitch.sin_val);
      crsp_r  <= eabv_pkg::mul_round(roll.cos_val, pitch.sin_val);
      nsrcp_r <= -eabv_pkg::mul_round(roll.sin_val, pitch.cos_val);
      crcp_r  <= eabv_pkg::mul_round(roll.cos_val, pitch.cos_val);
      crsy_r  <= eabv_pkg::mul_round(roll.cos_val, yaw.sin_val);
      crcy_r  <= eabv_pkg::mul_round(roll.cos_val, yaw.cos_val);
      srsy_r  <= eabv_pkg::mul_round(roll.sin_val, yaw.sin_val);
      srcy_r  <= eabv_pkg::mul_round(roll.sin_val, yaw.cos_val);
      nsp_r   <= -pitch.sin_val;
      cy_r    <= yaw.cos_val;
      sy_r    <= yaw.sin_val;

      srspcy_r <= eabv_pkg::mul_round(srsp_r, cy_r);
      srspsy_r <= eabv_pkg::mul_round(srsp_r, sy_r);
      crspcy_r <= eabv_pkg::mul_round(crsp_r, cy_r);
      crspsy_r <= eabv_pkg::mul_round(crsp_r, sy_r);
      crsy2_r  <= crsy_r;
      crcy2_r  <= crcy_r;
      srsy2_r  <= srsy_r;
      srcy2_r  <= srcy_r;
      cpcy2_r  <= cpcy_r;
      cpsy2_r  <= cpsy_r;
      nsp2_r   <= nsp_r;
      nsrcp2_r <= nsrcp_r;
      crcp2_r  <= crcp_r;
    end
  end

  always_comb begin
    rx_sum = S'(crsy2_r) - S'(srspcy_r);
    ry_sum = -S'(srspsy_r) - S'(crcy2_r);
    ux_sum = S'(crspcy_r) + S'(srsy2_r);
    uy_sum = S'(crspsy_r) - S'(srcy2_r);

    result.forward_x = cpcy2_r;
    result.forward_y = cpsy2_r;
    result.forward_z = nsp2_r;
    result.right_x   = eabv_pkg::sat_unit(rx_sum);
    result.right_y   = eabv_pkg::sat_unit(ry_sum);
    result.right_z   = nsrcp2_r;
    result.up_x      = eabv_pkg::sat_unit(ux_sum);
    result.up_y      = eabv_pkg::sat_unit(uy_sum);
    result.up_z      = crcp2_r;
  end

endmodule

// ----- design/euler_angles_to_basis_vectors.sv -----
// euler_angles_to_basis_vectors: pitch, yaw, roll to forward, right, up vectors in q1.14
// an input transaction passes the rom read, two multiply stages and the output register
// before out_valid; throughput one transaction per cycle, the whole pipe advances together
// and holds only while a result waits at the output register
// rst_n (synchronous) clears the stage valid bits; no state is kept between transactions
// depends on eabv_pkg, eabv_lane, eabv_merge
module euler_angles_to_basis_vectors (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  eabv_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output eabv_pkg::out_item_t out_data
);

  logic                 adv;
  logic                 v1_r, v2_r, v3_r, out_valid_r;
  logic                 v1_nxt, v2_nxt, v3_nxt, out_valid_nxt;
  eabv_pkg::trig_pair_t pitch_trig, yaw_trig, roll_trig;
  eabv_pkg::out_item_t  merged;
  eabv_pkg::out_item_t  out_data_r;

  assign adv      = out_ready | ~out_valid_r;
  assign in_ready = adv;

  eabv_lane u_pitch (.clk(clk), .en(adv), .angle(in_data.pitch_angle), .trig(pitch_trig));
  eabv_lane u_yaw   (.clk(clk), .en(adv), .angle(in_data.yaw_angle),   .trig(yaw_trig));
  eabv_lane u_roll  (.clk(clk), .en(adv), .angle(in_data.roll_angle),  .trig(roll_trig));

  eabv_merge u_merge (
    .clk    (clk),
    .en     (adv),
    .pitch  (pitch_trig),
    .yaw    (yaw_trig),
    .roll   (roll_trig),
    .result (merged)
  );

  always_comb begin
    v1_nxt        = v1_r;
    v2_nxt        = v2_r;
    v3_nxt        = v3_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      v1_nxt        = in_valid;
      v2_nxt        = v1_r;
      v3_nxt        = v2_r;
      out_valid_nxt = v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= merged;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
